@@ hdl/led_dimmer_sleep_controller_macros.svh @@
// assertion macros used by the checker file
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef LED_DIMMER_SLEEP_CONTROLLER_MACROS_SVH
`define LED_DIMMER_SLEEP_CONTROLLER_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define LDSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define LDSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/ldsc_pkg.sv @@
// types, codes and constants of the led dimmer sleep controller
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package ldsc_pkg;

    // request codes of an input item
    typedef enum logic [1:0] {
        REQ_TICK     = 2'd0,
        REQ_PIN_WAKE = 2'd1,
        REQ_WDT_WAKE = 2'd2
    } req_t;

    // operating modes
    typedef enum logic [1:0] {
        MODE_DIMMER = 2'd0,
        MODE_SLEEP  = 2'd1,
        MODE_ILLUM  = 2'd2
    } mode_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_SLEEP_TICKS     = 2'd0,
        CFG_DIM_TICKS       = 2'd1,
        CFG_DEBOUNCE_RELOAD = 2'd2,
        CFG_DUTY_TABLE      = 2'd3
    } cfg_idx_t;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 56;
    localparam int DUTY_W      = 7;
    localparam int LEVEL_W     = 3;
    localparam int LEVELS      = 8;

    localparam logic [31:0] SLEEP_TICKS_RESET     = 32'd1000;
    localparam logic [15:0] DIM_TICKS_RESET       = 16'd200;
    localparam logic [7:0]  DEBOUNCE_RELOAD_RESET = 8'd12;
    localparam logic [55:0] DUTY_TABLE_RESET      = 56'd55952637603905664;
    localparam logic [15:0] PRESS_TICKS_MAX       = 16'hFFFF;

    // configuration register set
    typedef struct packed {
        logic [31:0] sleep_ticks;
        logic [15:0] dim_ticks;
        logic [7:0]  debounce_reload;
        logic [55:0] duty_table;
    } cfg_t;

    // one result item
    typedef struct packed {
        logic [DUTY_W-1:0] duty_pct;
        mode_t             mode;
        logic              asleep;
    } result_t;

    // duty entry idx of the packed table
    function automatic logic [DUTY_W-1:0] table_duty(input logic [55:0] tbl,
                                                     input logic [LEVEL_W-1:0] idx);
        logic [55:0] shifted;
        shifted = tbl >> (int'(idx) * DUTY_W);
        return shifted[DUTY_W-1:0];
    endfunction

endpackage

@@ hdl/ldsc_core.sv @@
// controller state and its update for one item, registered on step
// depends on ldsc_pkg (codes, config struct, result struct, duty table lookup)
`timescale 1ns / 1ps

module ldsc_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  logic [1:0]      req_type,
    input  logic            button_level,
    input  ldsc_pkg::cfg_t  cfg,
    output ldsc_pkg::result_t result
);
    import ldsc_pkg::*;

    mode_t              mode_reg, mode_next;
    logic               halted_reg, halted_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [7:0]         debounce_reg, debounce_next;
    logic               sampled_reg, sampled_next;
    logic               pending_reg, pending_next;
    logic [31:0]        elapsed_reg, elapsed_next;
    logic [15:0]        press_reg, press_next;
    logic [DUTY_W-1:0]  duty_reg, duty_next;
    logic [LEVEL_W:0]   level_inc;

    // next state for the item presented on step
    always_comb
    begin
        mode_next     = mode_reg;
        halted_next   = halted_reg;
        level_next    = level_reg;
        debounce_next = debounce_reg;
        sampled_next  = sampled_reg;
        pending_next  = pending_reg;
        elapsed_next  = elapsed_reg;
        press_next    = press_reg;
        duty_next     = duty_reg;
        level_inc     = {1'b0, level_reg} + 1'b1;
        if (level_inc >= (LEVEL_W+1)'(LEVELS))
        begin
            level_inc = (LEVEL_W+1)'(1);
        end

        case (req_type)
            REQ_TICK:
            begin
                if (!halted_reg)
                begin
                    // timers
                    elapsed_next = elapsed_reg + 32'd1;
                    if (press_reg != PRESS_TICKS_MAX)
                    begin
                        press_next = press_reg + 16'd1;
                    end

                    // debounce and button sampling, the old sample is the previous level
                    if (debounce_reg != 8'd0)
                    begin
                        debounce_next = debounce_reg - 8'd1;
                    end
                    else
                    begin
                        debounce_next = cfg.debounce_reload;
                        sampled_next  = button_level;
                        if ((button_level && !sampled_reg) || pending_reg)
                        begin
                            pending_next = 1'b0;
                            mode_next    = MODE_DIMMER;
                            level_next   = level_inc[LEVEL_W-1:0];
                            duty_next    = table_duty(cfg.duty_table, level_next);
                            press_next   = 16'd0;
                        end
                    end

                    // mode timeouts
                    case (mode_next)
                        MODE_SLEEP:
                        begin
                            elapsed_next = 32'd0;
                            halted_next  = 1'b1;
                        end
                        MODE_DIMMER:
                        begin
                            if (press_next > cfg.dim_ticks)
                            begin
                                mode_next = (elapsed_next > cfg.sleep_ticks) ?
                                            MODE_SLEEP : MODE_ILLUM;
                            end
                            else
                            begin
                                duty_next = table_duty(cfg.duty_table, level_next);
                            end
                        end
                        MODE_ILLUM:
                        begin
                            duty_next = table_duty(cfg.duty_table, level_next);
                            if (elapsed_next > cfg.sleep_ticks)
                            begin
                                duty_next = '0;
                                mode_next = MODE_SLEEP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            REQ_PIN_WAKE:
            begin
                if (halted_reg)
                begin
                    halted_next  = 1'b0;
                    mode_next    = MODE_DIMMER;
                    press_next   = 16'd0;
                    pending_next = 1'b1;
                end
            end
            REQ_WDT_WAKE:
            begin
                // watchdog wake always clears halt; dimmer only with the button held
                if (halted_reg)
                begin
                    halted_next = 1'b0;
                    if (button_level)
                    begin
                        mode_next    = MODE_DIMMER;
                        press_next   = 16'd0;
                        pending_next = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_ILLUM;
            halted_reg   <= 1'b0;
            level_reg    <= LEVEL_W'(1);
            debounce_reg <= DEBOUNCE_RELOAD_RESET;
            sampled_reg  <= 1'b0;
            pending_reg  <= 1'b0;
            elapsed_reg  <= 32'd0;
            press_reg    <= 16'd0;
            duty_reg     <= '0;
        end
        else if (step)
        begin
            mode_reg     <= mode_next;
            halted_reg   <= halted_next;
            level_reg    <= level_next;
            debounce_reg <= debounce_next;
            sampled_reg  <= sampled_next;
            pending_reg  <= pending_next;
            elapsed_reg  <= elapsed_next;
            press_reg    <= press_next;
            duty_reg     <= duty_next;
        end
    end

    // result of the item is the updated state
    assign result.duty_pct = duty_next;
    assign result.mode     = mode_next;
    assign result.asleep   = halted_next;

endmodule

@@ hdl/led_dimmer_sleep_controller.sv @@
// top level of the led dimmer sleep controller: config registers and result queue
// depends on ldsc_pkg and ldsc_core
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  input    | in_valid, in_ready, req_type, button_level | in
//  result   | out_valid, out_ready, duty_pct, mode, asleep | out
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data  | in
//
// one item per cycle while in_ready is high; its state update is done in the cycle it is accepted
// the result is registered into the head entry on out_*, or into the skid entry while the head waits
// a two-entry result queue lets a new item in while one result waits
// in_ready drops only while two results are waiting; cfg_ready is always high
// rst_n asynchronously restores the reset state and config values
`timescale 1ns / 1ps

module led_dimmer_sleep_controller (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    req_type,
    input  logic                          button_level,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ldsc_pkg::DUTY_W-1:0]   duty_pct,
    output logic [1:0]                    mode,
    output logic                          asleep,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ldsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ldsc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ldsc_pkg::*;

    cfg_t    cfg_reg;
    result_t result_new;
    result_t head_reg;
    result_t skid_reg;
    logic    head_valid_reg;
    logic    skid_valid_reg;
    logic    push;
    logic    pop;

    assign in_ready  = !skid_valid_reg;
    assign cfg_ready = 1'b1;
    assign push      = in_valid && in_ready;
    assign pop       = head_valid_reg && out_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sleep_ticks     <= SLEEP_TICKS_RESET;
            cfg_reg.dim_ticks       <= DIM_TICKS_RESET;
            cfg_reg.debounce_reload <= DEBOUNCE_RELOAD_RESET;
            cfg_reg.duty_table      <= DUTY_TABLE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SLEEP_TICKS:     cfg_reg.sleep_ticks     <= cfg_data[31:0];
                CFG_DIM_TICKS:       cfg_reg.dim_ticks       <= cfg_data[15:0];
                CFG_DEBOUNCE_RELOAD: cfg_reg.debounce_reload <= cfg_data[7:0];
                CFG_DUTY_TABLE:      cfg_reg.duty_table      <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // controller state
    ldsc_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (push),
        .req_type     (req_type),
        .button_level (button_level),
        .cfg          (cfg_reg),
        .result       (result_new)
    );

    // result queue: head register plus skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!head_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                head_valid_reg <= 1'b1;
                skid_valid_reg <= push;
            end
            else
            begin
                head_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // queue payload
    always_ff @(posedge clk)
    begin
        if (!head_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                head_reg <= skid_reg;
                if (push)
                begin
                    skid_reg <= result_new;
                end
            end
            else if (push)
            begin
                head_reg <= result_new;
            end
        end
        else if (push)
        begin
            skid_reg <= result_new;
        end
    end

    assign out_valid = head_valid_reg;
    assign duty_pct  = head_reg.duty_pct;
    assign mode      = head_reg.mode;
    assign asleep    = head_reg.asleep;

endmodule

@@ hdl/ldsc_checker.sv @@
// port-level checks of the led dimmer sleep controller, bound to the top level
// depends on ldsc_pkg and led_dimmer_sleep_controller_macros.svh
`timescale 1ns / 1ps
`include "led_dimmer_sleep_controller_macros.svh"

module ldsc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [ldsc_pkg::DUTY_W-1:0]    duty_pct,
    input logic [1:0]                     mode,
    input logic                           asleep
);
    import ldsc_pkg::*;

    // a stalled result item holds
    `LDSC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(duty_pct) && $stable(mode) && $stable(asleep),
        "stalled result item changed")

    // a halted controller always reports sleep mode
    `LDSC_ASSERT_NOW(a_asleep_mode, out_valid && asleep, mode == MODE_SLEEP,
        "asleep reported outside sleep mode")

    // input stalls only with a result waiting
    `LDSC_ASSERT_NOW(a_ready_backpressure, !in_ready, out_valid,
        "input stalled with no result waiting")

    // a result appears only after an accepted item
    `LDSC_ASSERT_NOW(a_result_cause, $rose(out_valid), $past(in_valid && in_ready),
        "result item with no accepted input item")

endmodule

bind led_dimmer_sleep_controller ldsc_checker u_ldsc_checker (.*);
